>>> rtl/fsst_pkg.sv
`timescale 1ns / 1ps

package fsst_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned SID_W = 32;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_SET    = 2'd1,
    OP_UNSET  = 2'd2,
    OP_TOGGLE = 2'd3
  } req_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

>>> rtl/flow_sid_set_table.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// request   start in, busy out        req_type, sig_id
// result    done out (one cycle)      was_present, now_present, full_drop
//
// A request is taken when start is high and busy is low.
// To serve it, the block reads the memory once per slot, compares the last slot read,
// commits the write and then registers the result beat.
// The result beat is shown for one cycle with done high; the next request may
// be accepted during that cycle.
// The receiver cannot stall. Reset clears the slot valid marks and the controller.

module flow_sid_set_table #(
  parameter int unsigned TABLE_ENTRIES = fsst_pkg::TABLE_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type,
  input  logic [fsst_pkg::SID_W-1:0] sig_id,
  output logic                       done,
  output logic                       was_present,
  output logic                       now_present,
  output logic                       full_drop
);

  fsst_pkg::cmd_t    cmd;
  fsst_pkg::status_t status;

  fsst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  fsst_dp #(
    .ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req_type   (req_type),
    .sig_id     (sig_id),
    .done       (done),
    .was_present(was_present),
    .now_present(now_present),
    .full_drop  (full_drop)
  );

endmodule

>>> rtl/fsst_ram.sv
`timescale 1ns / 1ps

module fsst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fsst_ctrl.sv
`timescale 1ns / 1ps

module fsst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fsst_pkg::status_t status,
  output fsst_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_LAST  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> rtl/fsst_dp.sv
`timescale 1ns / 1ps

module fsst_dp #(
  parameter int unsigned ENTRIES = fsst_pkg::TABLE_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fsst_pkg::cmd_t             cmd,
  output fsst_pkg::status_t          status,
  input  logic [1:0]                 req_type,
  input  logic [fsst_pkg::SID_W-1:0] sig_id,
  output logic                       done,
  output logic                       was_present,
  output logic                       now_present,
  output logic                       full_drop
);

  localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

  logic [1:0]                 op;
  logic [fsst_pkg::SID_W-1:0] sid;
  logic [IDXW-1:0]            scan_idx;
  logic                       cmp_en;
  logic [IDXW-1:0]            cmp_idx;
  logic                       hit;
  logic [IDXW-1:0]            hit_idx;
  logic                       free_found;
  logic [IDXW-1:0]            free_idx;
  logic [ENTRIES-1:0]         valid;
  logic [fsst_pkg::SID_W-1:0] rdata;

  logic want_add;
  logic remove;
  logic add_ok;

  fsst_ram #(
    .WIDTH(fsst_pkg::SID_W),
    .DEPTH(ENTRIES)
  ) u_sids (
    .clk  (clk),
    .we   (cmd.commit && add_ok),
    .waddr(free_idx),
    .wdata(sid),
    .raddr(scan_idx),
    .rdata(rdata)
  );

  assign status.scan_last = (scan_idx == LAST_IDX);

  always_comb begin
    want_add = 1'b0;
    remove = 1'b0;
    case (fsst_pkg::req_op_t'(op))
      fsst_pkg::OP_QUERY: begin
      end
      fsst_pkg::OP_SET: begin
        want_add = !hit;
      end
      fsst_pkg::OP_UNSET: begin
        remove = hit;
      end
      fsst_pkg::OP_TOGGLE: begin
        remove = hit;
        want_add = !hit;
      end
      default: begin
      end
    endcase
    add_ok = want_add && free_found;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req_type;
      sid <= sig_id;
    end
    cmp_idx <= scan_idx;
    was_present <= hit;
    now_present <= (hit && !remove) || add_ok;
    full_drop <= want_add && !free_found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_en <= 1'b0;
      hit <= 1'b0;
      hit_idx <= '0;
      free_found <= 1'b0;
      free_idx <= '0;
      valid <= '0;
      done <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      done <= cmd.commit;
      if (cmd.load) begin
        scan_idx <= '0;
        hit <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan && !status.scan_last) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmp_en) begin
        if (valid[cmp_idx] && (rdata == sid) && !hit) begin
          hit <= 1'b1;
          hit_idx <= cmp_idx;
        end
        if (!valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx <= cmp_idx;
        end
      end
      if (cmd.commit) begin
        if (remove) begin
          valid[hit_idx] <= 1'b0;
        end
        if (add_ok) begin
          valid[free_idx] <= 1'b1;
        end
      end
    end
  end

endmodule
